FILE: design/smet_pkg.sv
`timescale 1ns / 1ps

package smet_pkg;

	// Internal arithmetic word; every Q12.36 value is sign-extended to it.
	localparam int WORD_W = 64;
	localparam int FRAC_BITS = 36;
	localparam int LIMIT_W = 32;
	localparam int LOG_W = 30;
	localparam int FRAC_LOG = 24;

	// Escape bound: |z|^2 > 16*16 in Q.36.
	localparam logic [WORD_W-1:0] ESCAPE_Q = 64'd256 << FRAC_BITS;
	// Smooth count offset 1.52876637 in Q.24, with the Q.16 rounding half.
	localparam logic [WORD_W-1:0] SMOOTH_K = 64'd25648444 + 64'd128;
	localparam logic [LOG_W-1:0] LOG_OFS_M = 30'd36 << FRAC_LOG;
	localparam logic [LOG_W-1:0] LOG_OFS_L = 30'd24 << FRAC_LOG;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd65535;

	// Result status codes.
	localparam logic [1:0] ST_ESCAPED = 2'd0;
	localparam logic [1:0] ST_PERIODIC = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	// Configuration register word index.
	localparam logic REG_LIMIT = 1'b0;

endpackage

FILE: design/smet_cmul.sv
`timescale 1ns / 1ps

module smet_cmul import smet_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic signed [WORD_W-1:0] a,
	input  logic signed [WORD_W-1:0] b,
	output logic signed [WORD_W-1:0] result,
	output logic                     done
);

	logic               run_q;
	logic [2:0]         ph_q;
	logic               done_q;
	logic [63:0]        am_q;
	logic [63:0]        bm_q;
	logic               neg_q;
	logic [63:0]        pp_q;
	logic [1:0]         sh_q;
	logic [127:0]       acc_q;
	logic signed [63:0] result_q;
	logic [31:0]        a_half;
	logic [31:0]        b_half;
	logic [127:0]       pp_shift;
	logic [92:0]        rnd_c;
	logic [62:0]        mag_c;

	// Sequencer: four partial products, then accumulation, rounding and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ph_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				ph_q <= 3'd0;
			end else if (run_q) begin
				if (ph_q == 3'd6) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
		end
	end

	// Halves of the magnitudes for the current partial product.
	assign a_half = ph_q[1] ? am_q[63:32] : am_q[31:0];
	assign b_half = ph_q[0] ? bm_q[63:32] : bm_q[31:0];

	always_comb begin
		case (sh_q)
			2'd0: pp_shift = {64'd0, pp_q};
			2'd1: pp_shift = {32'd0, pp_q, 32'd0};
			2'd2: pp_shift = {pp_q, 64'd0};
			default: pp_shift = 128'd0;
		endcase
	end

	// Round half away from zero on the magnitude, then saturate at 2^62.
	assign rnd_c = {1'b0, acc_q[127:36]} + {92'd0, acc_q[35]};
	assign mag_c = (rnd_c > (93'd1 << 62)) ? (63'd1 << 62) : rnd_c[62:0];

	// Datapath.
	always_ff @(posedge clk) begin
		if (go) begin
			am_q <= a[63] ? (64'd0 - a) : a;
			bm_q <= b[63] ? (64'd0 - b) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (run_q) begin
			if (ph_q <= 3'd3) begin
				pp_q <= a_half * b_half;
				sh_q <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
			end
			if (ph_q >= 3'd1 && ph_q <= 3'd4) begin
				acc_q <= acc_q + pp_shift;
			end
			if (ph_q == 3'd6) begin
				result_q <= neg_q ? (64'sd0 - $signed({1'b0, mag_c}))
					: $signed({1'b0, mag_c});
			end
		end
	end

	assign result = result_q;
	assign done = done_q;

endmodule

FILE: design/smet_log2.sv
`timescale 1ns / 1ps

module smet_log2 import smet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [WORD_W-1:0] v,
	output logic [LOG_W-1:0]  result,
	output logic              done
);

	logic        run_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [5:0]  p_q;
	logic [30:0] x_q;
	logic [23:0] frac_q;
	logic [6:0]  sft_c;
	logic        top_zero_c;
	logic [61:0] sq_c;
	logic [31:0] y_c;

	// Step counter: six normalize steps, one load, 24 squarings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 5'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (run_q) begin
				if (cnt_q == 5'd30) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	// Binary search for the top bit, 32 down to 1.
	always_comb begin
		case (cnt_q)
			5'd0: sft_c = 7'd32;
			5'd1: sft_c = 7'd16;
			5'd2: sft_c = 7'd8;
			5'd3: sft_c = 7'd4;
			5'd4: sft_c = 7'd2;
			5'd5: sft_c = 7'd1;
			default: sft_c = 7'd0;
		endcase
	end

	assign top_zero_c = (v_q >> (7'd64 - sft_c)) == 64'd0;

	// One squaring per cycle on the Q1.30 mantissa.
	assign sq_c = x_q * x_q;
	assign y_c = sq_c[61:30];

	always_ff @(posedge clk) begin
		if (go) begin
			v_q <= v;
			p_q <= 6'd63;
			frac_q <= 24'd0;
		end else if (run_q) begin
			if (cnt_q <= 5'd5) begin
				if (top_zero_c) begin
					v_q <= v_q << sft_c;
					p_q <= p_q - sft_c[5:0];
				end
			end else if (cnt_q == 5'd6) begin
				x_q <= v_q[63:33];
			end else begin
				if (y_c[31]) begin
					x_q <= y_c[31:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					x_q <= y_c[30:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
		end
	end

	assign result = {p_q, frac_q};
	assign done = done_q;

endmodule

FILE: design/smooth_escape_time_iteration.sv
`timescale 1ns / 1ps
// Each iteration takes three products through the shared 32x32 multiplier
// plus limit, escape, two add and period steps; an escaping iteration
// finishes with the two log2 passes.
// The result strobe is a register set by the last step; iterations are data dependent.
// Throughput: one request at a time; busy stays high until the result strobe,
// which the receiver cannot stall. Reset clears the sequencer and the largest-count
// register and sets the limit to 65535.

module smooth_escape_time_iteration import smet_pkg::*; #(
	parameter int VALUE_WIDTH = 48,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] z_real,
	input  logic signed [VALUE_WIDTH-1:0] z_imag,
	input  logic signed [VALUE_WIDTH-1:0] c_real,
	input  logic signed [VALUE_WIDTH-1:0] c_imag,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [COUNT_WIDTH-1:0]        iteration_count,
	output logic signed [48:0]            smooth_count,
	output logic signed [VALUE_WIDTH-1:0] final_z_real,
	output logic signed [VALUE_WIDTH-1:0] final_z_imag,
	output logic [COUNT_WIDTH-1:0]        largest_count_seen
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_MRR  = 4'd2;
	localparam logic [3:0] S_MII  = 4'd3;
	localparam logic [3:0] S_ESC  = 4'd4;
	localparam logic [3:0] S_MRI  = 4'd5;
	localparam logic [3:0] S_ADD1 = 4'd6;
	localparam logic [3:0] S_ADD2 = 4'd7;
	localparam logic [3:0] S_PER  = 4'd8;
	localparam logic [3:0] S_LOG1 = 4'd9;
	localparam logic [3:0] S_LOG2 = 4'd10;
	localparam logic [3:0] S_SM   = 4'd11;

	localparam logic signed [64:0] VMAX = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
	localparam logic signed [64:0] VMIN = -(65'sd1 <<< (VALUE_WIDTH - 1));

	logic [3:0]                    state_q;
	logic [LIMIT_W-1:0]            limit_q;
	logic signed [VALUE_WIDTH-1:0] zr_q;
	logic signed [VALUE_WIDTH-1:0] zi_q;
	logic signed [VALUE_WIDTH-1:0] cr_q;
	logic signed [VALUE_WIDTH-1:0] ci_q;
	logic signed [VALUE_WIDTH-1:0] sr_q;
	logic signed [VALUE_WIDTH-1:0] si_q;
	logic                          saved_q;
	logic [LIMIT_W-1:0]            i_q;
	logic [LIMIT_W:0]              dl_q;
	logic signed [63:0]            r2_q;
	logic signed [63:0]            i2_q;
	logic signed [63:0]            x_q;
	logic signed [63:0]            t_q;
	logic [LOG_W-1:0]              ll_q;
	logic                          done_q;
	logic [COUNT_WIDTH-1:0]        largest_q;
	logic [1:0]                    status_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic signed [48:0]            smooth_q;
	logic signed [VALUE_WIDTH-1:0] fzr_q;
	logic signed [VALUE_WIDTH-1:0] fzi_q;

	logic signed [63:0] zr_x, zi_x, cr_x, ci_x;
	logic signed [63:0] mul_a, mul_b, mul_res;
	logic               mul_go, mul_done;
	logic [63:0]        log_v;
	logic               log_go, log_done;
	logic [LOG_W-1:0]   log_res;
	logic [63:0]        m_c;
	logic               escape_c;
	logic               limit_hit_c;
	logic               match_c;
	logic signed [63:0] nr_c, t_c, ni_c;
	logic [63:0]        s_c;
	logic               fin_c;
	logic [1:0]         fin_status_c;
	logic [COUNT_WIDTH-1:0] fin_count_c;
	logic               cfg_wr;

	// Saturate an exact sum to the signed value range.
	function automatic logic signed [63:0] clamp_v(input logic signed [64:0] s);
		logic signed [64:0] r;
		begin
			r = s;
			if (s > VMAX) r = VMAX;
			if (s < VMIN) r = VMIN;
			clamp_v = r[63:0];
		end
	endfunction

	// Configuration register.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? limit_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata;
		end
	end

	assign zr_x = 64'(zr_q);
	assign zi_x = 64'(zi_q);
	assign cr_x = 64'(cr_q);
	assign ci_x = 64'(ci_q);

	// Shared product unit and log2 unit.
	assign mul_a = (state_q == S_MRR) ? zi_x : zr_x;
	assign mul_b = (state_q == S_CHK) ? zr_x : zi_x;

	smet_cmul u_cmul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.result (mul_res),
		.done   (mul_done)
	);

	assign log_v = (state_q == S_ESC) ? m_c : 64'(log_res - LOG_OFS_M);

	smet_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (log_go),
		.v      (log_v),
		.result (log_res),
		.done   (log_done)
	);

	// Iteration arithmetic.
	assign limit_hit_c = (i_q == limit_q);
	assign m_c = r2_q + i2_q;
	assign escape_c = m_c > ESCAPE_Q;
	assign nr_c = clamp_v(65'(r2_q) - 65'(i2_q) + 65'(cr_x));
	assign t_c = clamp_v(65'(x_q) + 65'(x_q));
	assign ni_c = clamp_v(65'(t_q) + 65'(ci_x));
	assign match_c = saved_q && zr_q == sr_q && zi_q == si_q;
	assign s_c = ({32'd0, i_q} << FRAC_LOG) + SMOOTH_K - 64'(ll_q - LOG_OFS_L);

	assign mul_go = (state_q == S_CHK && !limit_hit_c) || (state_q == S_MRR && mul_done)
		|| (state_q == S_ESC && !escape_c);
	assign log_go = (state_q == S_ESC && escape_c) || (state_q == S_LOG1 && log_done);

	// Exit decision.
	always_comb begin
		fin_c = 1'b0;
		fin_status_c = ST_ESCAPED;
		fin_count_c = COUNT_WIDTH'(i_q);
		case (state_q)
			S_CHK: begin
				fin_c = limit_hit_c;
				fin_status_c = ST_LIMIT;
			end
			S_PER: begin
				fin_c = match_c;
				fin_status_c = ST_PERIODIC;
				fin_count_c = COUNT_WIDTH'(i_q + 32'd1);
			end
			S_SM: begin
				fin_c = 1'b1;
				fin_status_c = ST_ESCAPED;
			end
			default: begin
				fin_c = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			largest_q <= '0;
		end else begin
			done_q <= fin_c;
			if (fin_c && fin_status_c != ST_PERIODIC && fin_count_c > largest_q) begin
				largest_q <= fin_count_c;
			end
			case (state_q)
				S_IDLE: if (start) state_q <= S_CHK;
				S_CHK: state_q <= limit_hit_c ? S_IDLE : S_MRR;
				S_MRR: if (mul_done) state_q <= S_MII;
				S_MII: if (mul_done) state_q <= S_ESC;
				S_ESC: state_q <= escape_c ? S_LOG1 : S_MRI;
				S_MRI: if (mul_done) state_q <= S_ADD1;
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: state_q <= S_PER;
				S_PER: state_q <= match_c ? S_IDLE : S_CHK;
				S_LOG1: if (log_done) state_q <= S_LOG2;
				S_LOG2: if (log_done) state_q <= S_SM;
				S_SM: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Iteration state and result datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				zr_q <= z_real;
				zi_q <= z_imag;
				cr_q <= c_real;
				ci_q <= c_imag;
				i_q <= '0;
				dl_q <= 33'd1;
				saved_q <= 1'b0;
			end
			S_MRR: if (mul_done) r2_q <= mul_res;
			S_MII: if (mul_done) i2_q <= mul_res;
			S_MRI: if (mul_done) x_q <= mul_res;
			S_ADD1: begin
				zr_q <= nr_c[VALUE_WIDTH-1:0];
				t_q <= t_c;
			end
			S_ADD2: zi_q <= ni_c[VALUE_WIDTH-1:0];
			S_PER: begin
				if (!match_c) begin
					if ({1'b0, i_q} > dl_q) begin
						sr_q <= zr_q;
						si_q <= zi_q;
						saved_q <= 1'b1;
						dl_q <= dl_q << 1;
					end
					i_q <= i_q + 32'd1;
				end
			end
			S_LOG2: if (log_done) ll_q <= log_res;
			default: begin
			end
		endcase
		if (fin_c) begin
			status_q <= fin_status_c;
			count_q <= fin_count_c;
			smooth_q <= (fin_status_c == ST_ESCAPED) ? $signed(s_c[56:8]) : 49'sd0;
			fzr_q <= zr_q;
			fzi_q <= zi_q;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign iteration_count = count_q;
	assign smooth_count = smooth_q;
	assign final_z_real = fzr_q;
	assign final_z_imag = fzi_q;
	assign largest_count_seen = largest_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import smet_pkg::*;

	localparam int VW = 48;
	localparam int CW = 32;
	// Word index of the second register slot, which holds nothing.
	localparam int REG_UNUSED = 1;
	localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
	localparam longint VMIN = -(64'sd1 <<< (VW - 1));

	typedef struct {
		logic [1:0]    status;
		logic [CW-1:0] count;
		logic [48:0]   smooth;
		logic [VW-1:0] zr;
		logic [VW-1:0] zi;
		logic [CW-1:0] largest;
	} orbit_result_t;

	// Holds predicted orbit results in request order and compares the block's output.
	class orbit_scoreboard;
		orbit_result_t pending[$];
		int mismatches = 0;

		function void note_request(orbit_result_t r);
			pending.push_back(r);
		endfunction

		function void check_result(orbit_result_t got);
			orbit_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d count %0d", got.status, got.count);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.count !== want.count ||
					got.smooth !== want.smooth || got.zr !== want.zr ||
					got.zi !== want.zi || got.largest !== want.largest) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: status %0d/%0d count %0d/%0d smooth %h/%h",
						want.status, got.status, want.count, got.count, want.smooth, got.smooth);
					$display("  z %h %h / %h %h largest %0d/%0d", want.zr, want.zi,
						got.zr, got.zi, want.largest, got.largest);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic signed [VW-1:0] z_real = '0, z_imag = '0, c_real = '0, c_imag = '0;
	logic done;
	logic [1:0] status;
	logic [CW-1:0] iteration_count;
	logic signed [48:0] smooth_count;
	logic signed [VW-1:0] final_z_real, final_z_imag;
	logic [CW-1:0] largest_count_seen;

	smooth_escape_time_iteration #(.VALUE_WIDTH(VW), .COUNT_WIDTH(CW)) i_dut (.*);

	orbit_scoreboard sb = new();
	bit [31:0] limit_model = LIMIT_RESET;
	bit [31:0] largest_model = '0;
	int item_no = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#100_000_000;
		$display("FAIL");
		$finish;
	end

	// Rounded fixed-point product, magnitude saturated at 2^62.
	function automatic bit [63:0] q_mul(bit [63:0] a, bit [63:0] b);
		bit [63:0] ua, ub, q;
		bit [127:0] prod;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		prod = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		q = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
		return (a[63] ^ b[63]) ? -q : q;
	endfunction

	// Exact sum clamped to the signed value range.
	function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
		logic signed [65:0] s;
		s = $signed({{2{a[63]}}, a}) + $signed({{2{b[63]}}, b});
		if (s > VMAX) s = VMAX;
		if (s < VMIN) s = VMIN;
		return s[63:0];
	endfunction

	// Base-2 logarithm in Q.24 by repeated squaring of the normalized mantissa.
	function automatic bit [63:0] log2_q24(bit [63:0] v);
		int p;
		bit [63:0] x, frac;
		p = 0;
		frac = 0;
		while (p < 63 && (v >> (p + 1)) != 0) p++;
		x = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
		for (int k = 0; k < 24; k++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(p) << 24) | frac;
	endfunction

	// Runs the orbit of one request and updates the largest-count copy.
	function automatic orbit_result_t predict_orbit(bit [VW-1:0] zr0, bit [VW-1:0] zi0,
			bit [VW-1:0] cr0, bit [VW-1:0] ci0);
		orbit_result_t r;
		bit [63:0] zr, zi, cr, ci, sr, si, r2, i2, x, m, nr, ni, i, deadline, l2, ll, s;
		bit saved;
		logic [1:0] st;
		zr = {{16{zr0[VW-1]}}, zr0};
		zi = {{16{zi0[VW-1]}}, zi0};
		cr = {{16{cr0[VW-1]}}, cr0};
		ci = {{16{ci0[VW-1]}}, ci0};
		i = 0;
		deadline = 1;
		sr = 0;
		si = 0;
		m = 0;
		saved = 0;
		forever begin
			if (i == limit_model) begin
				st = ST_LIMIT;
				break;
			end
			r2 = q_mul(zr, zr);
			i2 = q_mul(zi, zi);
			m = r2 + i2;
			if (m > ESCAPE_Q) begin
				st = ST_ESCAPED;
				break;
			end
			x = q_mul(zr, zi);
			ni = sat_sum(sat_sum(x, x), ci);
			nr = sat_sum(r2 - i2, cr);
			zr = nr;
			zi = ni;
			if (saved && zr == sr && zi == si) begin
				st = ST_PERIODIC;
				break;
			end
			if (i > deadline) begin
				sr = zr;
				si = zi;
				saved = 1;
				deadline = deadline << 1;
			end
			i++;
		end
		r.status = st;
		r.smooth = '0;
		if (st == ST_PERIODIC) begin
			r.count = CW'(i + 1);
		end else begin
			r.count = CW'(i);
			if (r.count > largest_model) largest_model = r.count;
		end
		if (st == ST_ESCAPED) begin
			l2 = log2_q24(m) - (64'd36 << 24);
			ll = log2_q24(l2) - (64'd24 << 24);
			s = (i << 24) + SMOOTH_K + (64'd8 << 24) - ll;
			r.smooth = 49'((s >> 8) - (64'd8 << 16));
		end
		r.zr = zr[VW-1:0];
		r.zi = zi[VW-1:0];
		r.largest = largest_model;
		return r;
	endfunction

	// Monitor: predict each accepted request and check each result strobe.
	always @(posedge clk) begin
		orbit_result_t got;
		if (start && !busy)
			sb.note_request(predict_orbit(z_real, z_imag, c_real, c_imag));
		if (done) begin
			got.status = status;
			got.count = iteration_count;
			got.smooth = smooth_count;
			got.zr = final_z_real;
			got.zi = final_z_imag;
			got.largest = largest_count_seen;
			sb.check_result(got);
		end
	end

	task automatic write_reg(int index, bit [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(index * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_LIMIT) limit_model = value;
	endtask

	// Present one request and hold it until the block takes it.
	task automatic send_request(longint zr, longint zi, longint cr, longint ci);
		item_no++;
		if ((item_no < 300 || item_no > 420) && $urandom_range(99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		z_real <= VW'(zr);
		z_imag <= VW'(zi);
		c_real <= VW'(cr);
		c_imag <= VW'(ci);
		do @(posedge clk); while (!(start && !busy));
	endtask

	task automatic drain;
		@(posedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic longint rand_q(int shift);
		longint v;
		v = {$urandom, $urandom};
		return v >>> shift;
	endfunction

	task automatic directed_set;
		send_request('0, '0, '0, '0);
		send_request(ONE_Q, '0, '0, '0);
		send_request('0, '0, -2 * ONE_Q, '0);
		send_request('0, '0, '0, ONE_Q);
		send_request(ONE_Q / 2, ONE_Q / 2, '0, '0);
		send_request(VMAX, VMAX, '0, '0);
		send_request(VMIN, VMIN, VMIN, VMIN);
		send_request(VMIN, '0, VMAX, VMAX);
		send_request(15 * ONE_Q, '0, VMAX, '0);
		send_request('0, '0, 5 * ONE_Q / 2, '0);
		send_request('0, 3 * ONE_Q, ONE_Q / 16, -ONE_Q / 8);
	endtask

	// Mostly Mandelbrot and Julia points near the set, some wider points, the rest full-range noise.
	task automatic random_set(int n);
		int kind;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(99);
			if (kind < 45)
				send_request('0, '0, rand_q(26), rand_q(26));
			else if (kind < 80)
				send_request(rand_q(26), rand_q(26), rand_q(27), rand_q(27));
			else if (kind < 90)
				send_request(rand_q(20), rand_q(22), rand_q(24), rand_q(18));
			else
				send_request(rand_q(16), rand_q(16), rand_q(16), rand_q(16));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset limit, then the zero, one and largest limits.
		directed_set();
		drain();
		write_reg(REG_LIMIT, 32'd0);
		directed_set();
		drain();
		write_reg(REG_LIMIT, 32'd1);
		write_reg(REG_UNUSED, 32'd3);
		directed_set();
		drain();
		write_reg(REG_LIMIT, 32'hFFFF_FFFF);
		directed_set();
		drain();

		// Random phases with short limits, one with a longer limit.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_LIMIT, $urandom_range(2, 60));
			random_set(100);
			drain();
		end
		write_reg(REG_LIMIT, 32'd200);
		random_set(50);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
